### rtl/assert_macros.svh
// Assertion helpers for the RTL, included by polar_association_score.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: property failed");

// Flag a condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

### rtl/pas_pkg.sv
package pas_pkg;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Pipelined divider shapes: dividend, divisor and quotient widths
  localparam int DIV_QW = 22;
  localparam int AZ_NW  = 34;
  localparam int AZ_DW  = 19;
  localparam int HT_NW  = 32;
  localparam int HT_DW  = 16;
  localparam int RG_NW  = 41;
  localparam int RG_DW  = 20;
  localparam int SC_QW  = 16;
  localparam int SC_NW  = 32;
  localparam int SC_DW  = 17;

  // Depth of the exponential unit
  localparam int EXP_LAT = 3;

  // Fixed-point constants, Q.16 where a fraction
  localparam logic [16:0] Q_ONE        = 17'h10000;
  localparam logic [19:0] SIG_BASE     = 20'd200000;   // 2 m expressed as 100*mm
  localparam logic [22:0] GAP_SCALE    = 23'd6553600;  // 100 * 65536
  localparam logic [16:0] LOG2E_Q16    = 17'd94548;
  localparam logic [19:0] RECIP_TEN    = 20'd838861;   // 2^23 / 10, rounded up
  localparam logic [19:0] RAW_BASE     = 20'd458752;   // 7 * 65536
  localparam logic [16:0] AZ_SHAPE_MAX = 17'd45875;    // largest azIoU below 0.7

  typedef enum logic [2:0] {
    REG_AZ_CENTER    = 3'd0,
    REG_AZ_HALF_SPAN = 3'd1,
    REG_RANGE_MIN    = 3'd2,
    REG_Z_MIN        = 3'd3,
    REG_Z_MAX        = 3'd4,
    REG_AREA         = 3'd5,
    REG_IS_VEHICLE   = 3'd6,
    REG_MIN_SCORE    = 3'd7
  } pas_reg_e;

  typedef struct packed {
    logic [15:0] az_center;
    logic [15:0] az_half_span;
    logic [17:0] range_min;
    logic [15:0] z_min;
    logic [15:0] z_max;
    logic [15:0] area;
    logic        is_vehicle;
    logic [15:0] min_score;
  } pas_cfg_t;

  // round(65536 * 2^(-j/16)) for j = 0..16
  function automatic logic [16:0] exp2_tab(input logic [4:0] idx);
    logic [16:0] val;
    case (idx)
      5'd0:    val = 17'd65536;
      5'd1:    val = 17'd62757;
      5'd2:    val = 17'd60097;
      5'd3:    val = 17'd57549;
      5'd4:    val = 17'd55109;
      5'd5:    val = 17'd52773;
      5'd6:    val = 17'd50535;
      5'd7:    val = 17'd48393;
      5'd8:    val = 17'd46341;
      5'd9:    val = 17'd44376;
      5'd10:   val = 17'd42495;
      5'd11:   val = 17'd40693;
      5'd12:   val = 17'd38968;
      5'd13:   val = 17'd37316;
      5'd14:   val = 17'd35734;
      5'd15:   val = 17'd34219;
      default: val = 17'd32768;
    endcase
    return val;
  endfunction

endpackage

### rtl/pas_if.sv
interface pas_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] meas_az_center;
  logic        [15:0] meas_az_half_span;
  logic        [17:0] meas_range_min;
  logic signed [15:0] meas_z_min;
  logic signed [15:0] meas_z_max;
  logic        [15:0] meas_area;
  logic               extent_trusted;

  modport source (
    output valid, meas_az_center, meas_az_half_span, meas_range_min,
           meas_z_min, meas_z_max, meas_area, extent_trusted,
    input  ready
  );
  modport sink (
    input  valid, meas_az_center, meas_az_half_span, meas_range_min,
           meas_z_min, meas_z_max, meas_area, extent_trusted,
    output ready
  );
endinterface

interface pas_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] score;
  logic        shape_change;

  modport source (output valid, score, shape_change, input ready);
  modport sink (input valid, score, shape_change, output ready);
endinterface

### rtl/pas_cfg.sv
module pas_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pas_pkg::ADDR_W-1:0]  paddr,
  input  logic [pas_pkg::DATA_W-1:0]  pwdata,
  output logic [pas_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output pas_pkg::pas_cfg_t           cfg_o
);
  import pas_pkg::*;

  pas_cfg_t cfg_q;
  pas_reg_e idx;
  logic     wr;

  assign idx    = pas_reg_e'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write registers in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_AZ_CENTER:    cfg_q.az_center    <= pwdata[15:0];
        REG_AZ_HALF_SPAN: cfg_q.az_half_span <= pwdata[15:0];
        REG_RANGE_MIN:    cfg_q.range_min    <= pwdata[17:0];
        REG_Z_MIN:        cfg_q.z_min        <= pwdata[15:0];
        REG_Z_MAX:        cfg_q.z_max        <= pwdata[15:0];
        REG_AREA:         cfg_q.area         <= pwdata[15:0];
        REG_IS_VEHICLE:   cfg_q.is_vehicle   <= pwdata[0];
        REG_MIN_SCORE:    cfg_q.min_score    <= pwdata[15:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_AZ_CENTER:    prdata[15:0] = cfg_q.az_center;
      REG_AZ_HALF_SPAN: prdata[15:0] = cfg_q.az_half_span;
      REG_RANGE_MIN:    prdata[17:0] = cfg_q.range_min;
      REG_Z_MIN:        prdata[15:0] = cfg_q.z_min;
      REG_Z_MAX:        prdata[15:0] = cfg_q.z_max;
      REG_AREA:         prdata[15:0] = cfg_q.area;
      REG_IS_VEHICLE:   prdata[0]    = cfg_q.is_vehicle;
      REG_MIN_SCORE:    prdata[15:0] = cfg_q.min_score;
    endcase
  end
endmodule

### rtl/pas_div.sv
// Restoring divider, one quotient bit per pipeline stage.
// The caller keeps num_i >> QW below den_i, so the quotient fits QW bits.
module pas_div #(
  parameter int NW = 34,
  parameter int DW = 19,
  parameter int QW = 22
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] wrk_q [QW];
  logic [DW-1:0] den_q [QW];

  genvar s;
  for (s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] w_in;
    logic [DW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign r_in = DW'(num_i >> QW);
      assign w_in = num_i[QW-1:0];
      assign d_in = den_i;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign w_in = wrk_q[s-1];
      assign d_in = den_q[s-1];
    end

    // Shift in the next dividend bit and subtract when it fits
    assign trial = {r_in, w_in[QW-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
        wrk_q[s] <= {w_in[QW-2:0], ge};
        den_q[s] <= d_in;
      end
    end
  end

  assign quo_o = wrk_q[QW-1];
endmodule

### rtl/pas_exp.sv
// exp(-x) for x in Q.16 through 2^-(x*log2 e): table with linear
// interpolation over 16 segments, then a right shift by the integer part.
module pas_exp (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [pas_pkg::DIV_QW-1:0] x_i,
  output logic [16:0]                rad_o
);
  import pas_pkg::*;

  logic [19:0] xc;
  logic [36:0] yprod;
  logic [20:0] y_q;
  logic [3:0]  seg;
  logic [11:0] frac;
  logic [16:0] t0;
  logic [16:0] t1;
  logic [11:0] dif;
  logic [23:0] dm;
  logic [16:0] t0_q;
  logic [23:0] dm_q;
  logic [4:0]  k_q;
  logic        kbig_q;
  logic [16:0] v;
  logic [16:0] rad_q;

  // Clamp: any x from 2^20 up drives the shift count past 16
  assign xc    = (|x_i[DIV_QW-1:20]) ? '1 : x_i[19:0];
  assign yprod = {17'b0, xc} * {20'b0, LOG2E_Q16};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= yprod[36:16];
    end
  end

  // Look up the segment and scale its slope by the fraction
  assign seg  = y_q[15:12];
  assign frac = y_q[11:0];
  assign t0   = exp2_tab({1'b0, seg});
  assign t1   = exp2_tab({1'b0, seg} + 5'd1);
  assign dif  = 12'(t0 - t1);
  assign dm   = {12'b0, dif} * {12'b0, frac};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q   <= t0;
      dm_q   <= dm;
      k_q    <= y_q[20:16];
      kbig_q <= y_q[20:16] > 5'd16;
    end
  end

  // Interpolate and apply the power of two
  assign v = t0_q - 17'(dm_q >> 12);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q <= kbig_q ? 17'd0 : (v >> k_q);
    end
  end

  assign rad_o = rad_q;
endmodule

### rtl/pas_delay.sv
// Payload delay line that advances with the pipeline.
module pas_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] dly_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= d_i;
      for (int n = 1; n < DEPTH; n++) begin
        dly_q[n] <= dly_q[n-1];
      end
    end
  end

  assign q_o = dly_q[DEPTH-1];
endmodule

### rtl/polar_association_score.sv
// Throughput: one transaction per cycle unless the output stalls; the depth
// is set by the two bit-per-stage dividers (22 stages for the three terms, 16
// for the rescale).
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset clears all valid bits and sets every configuration register to zero.
`include "assert_macros.svh"

module polar_association_score (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pas_in_if.sink                      in_i,
  pas_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pas_pkg::ADDR_W-1:0]  paddr,
  input  logic [pas_pkg::DATA_W-1:0]  pwdata,
  output logic [pas_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import pas_pkg::*;

  localparam int ST_DIV_IN = 4;
  localparam int ST_EXP_IN = ST_DIV_IN + DIV_QW;
  localparam int ST_MUL    = ST_EXP_IN + EXP_LAT + 1;
  localparam int ST_SC_IN  = ST_MUL + 3;
  localparam int ST_SC_OUT = ST_SC_IN + SC_QW;
  localparam int NSTG      = ST_SC_OUT + 1;

  pas_cfg_t cfg;
  logic     adv;
  logic [NSTG-1:0] vld_q;

  pas_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance every stage together unless the result register is held
  assign adv        = !vld_q[NSTG-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  // Stage 1: capture the transaction
  logic signed [15:0] s1_mac;
  logic        [15:0] s1_mah;
  logic        [17:0] s1_mr;
  logic signed [15:0] s1_mzl;
  logic signed [15:0] s1_mzh;
  logic        [15:0] s1_marea;
  logic               s1_trust;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mac   <= in_i.meas_az_center;
      s1_mah   <= in_i.meas_az_half_span;
      s1_mr    <= in_i.meas_range_min;
      s1_mzl   <= in_i.meas_z_min;
      s1_mzh   <= in_i.meas_z_max;
      s1_marea <= in_i.meas_area;
      s1_trust <= in_i.extent_trusted;
    end
  end

  // Stage 2: wrapped center distance, range gap, height bounds, area test
  logic        [15:0] diff16;
  logic        [16:0] dmag;
  logic        [17:0] gap;
  logic        [17:0] rmax;
  logic signed [15:0] tzmin;
  logic signed [15:0] tzmax;
  logic        [15:0] big;
  logic        [15:0] sml;
  logic               pre;
  logic        [16:0] s2_dmag;
  logic        [15:0] s2_ha;
  logic        [17:0] s2_gap;
  logic        [17:0] s2_rmax;
  logic signed [15:0] s2_zlo;
  logic signed [15:0] s2_zhi;
  logic signed [15:0] s2_zbot;
  logic signed [15:0] s2_ztop;
  logic               s2_pre;

  assign diff16 = s1_mac - cfg.az_center;
  assign dmag   = diff16[15] ? 17'(Q_ONE - {1'b0, diff16}) : {1'b0, diff16};
  assign gap    = (s1_mr > cfg.range_min) ? s1_mr - cfg.range_min : cfg.range_min - s1_mr;
  assign rmax   = (s1_mr > cfg.range_min) ? s1_mr : cfg.range_min;
  assign tzmin  = cfg.z_min;
  assign tzmax  = cfg.z_max;
  assign big    = (s1_marea > cfg.area) ? s1_marea : cfg.area;
  assign sml    = (s1_marea > cfg.area) ? cfg.area : s1_marea;
  assign pre    = cfg.is_vehicle && s1_trust && (|s1_marea) && (|cfg.area) &&
                  ({1'b0, big} > {sml, 1'b0});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_dmag <= dmag;
      s2_ha   <= s1_mah;
      s2_gap  <= gap;
      s2_rmax <= rmax;
      s2_zlo  <= (s1_mzl > tzmin) ? s1_mzl : tzmin;
      s2_zhi  <= (s1_mzh < tzmax) ? s1_mzh : tzmax;
      s2_zbot <= (s1_mzl < tzmin) ? s1_mzl : tzmin;
      s2_ztop <= (s1_mzh > tzmax) ? s1_mzh : tzmax;
      s2_pre  <= pre;
    end
  end

  // Stage 3: interval ends, height overlap and span, radial scale
  logic signed [18:0] ha19;
  logic signed [18:0] hb19;
  logic signed [18:0] d19;
  logic signed [18:0] nha;
  logic signed [18:0] dmh;
  logic signed [18:0] dph;
  logic signed [18:0] s3_left;
  logic signed [18:0] s3_right;
  logic signed [16:0] s3_ov;
  logic signed [16:0] s3_span;
  logic        [19:0] s3_sig;
  logic        [40:0] s3_gapn;
  logic        [18:0] s3_hsum2;

  assign ha19 = signed'({3'b0, s2_ha});
  assign hb19 = signed'({3'b0, cfg.az_half_span});
  assign d19  = signed'({2'b0, s2_dmag});
  assign nha  = -ha19;
  assign dmh  = d19 - hb19;
  assign dph  = d19 + hb19;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_left  <= (nha > dmh) ? nha : dmh;
      s3_right <= (ha19 < dph) ? ha19 : dph;
      s3_ov    <= {s2_zhi[15], s2_zhi} - {s2_zlo[15], s2_zlo};
      s3_span  <= {s2_ztop[15], s2_ztop} - {s2_zbot[15], s2_zbot};
      s3_sig   <= SIG_BASE + {2'b0, s2_rmax} + {1'b0, s2_rmax, 1'b0};
      s3_gapn  <= {23'b0, s2_gap} * {18'b0, GAP_SCALE};
      s3_hsum2 <= 19'({s2_ha, 1'b0}) + 19'({cfg.az_half_span, 1'b0});
    end
  end

  // Stage 4: divider operands; empty spans divide zero by one
  logic [17:0]       inter;
  logic [18:0]       uni;
  logic [15:0]       ovc;
  logic              span_pos;
  logic [AZ_NW-1:0]  s4_az_num;
  logic [AZ_DW-1:0]  s4_az_den;
  logic [HT_NW-1:0]  s4_ht_num;
  logic [HT_DW-1:0]  s4_ht_den;
  logic [RG_NW-1:0]  s4_rg_num;
  logic [RG_DW-1:0]  s4_rg_den;

  assign inter    = (s3_right > s3_left) ? 18'(s3_right - s3_left) : '0;
  assign uni      = s3_hsum2 - {1'b0, inter};
  assign ovc      = s3_ov[16] ? '0 : s3_ov[15:0];
  assign span_pos = !s3_span[16] && (|s3_span[15:0]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_az_num <= (uni == '0) ? '0 : {inter, 16'b0};
      s4_az_den <= (uni == '0) ? 19'd1 : uni;
      s4_ht_num <= span_pos ? {ovc, 16'b0} : '0;
      s4_ht_den <= span_pos ? s3_span[15:0] : 16'd1;
      s4_rg_num <= s3_gapn;
      s4_rg_den <= s3_sig;
    end
  end

  // Term dividers
  logic [DIV_QW-1:0] az_quo;
  logic [DIV_QW-1:0] ht_quo;
  logic [DIV_QW-1:0] rg_quo;

  pas_div #(.NW(AZ_NW), .DW(AZ_DW), .QW(DIV_QW)) u_az_div (
    .clk_i (clk_i), .en_i (adv), .num_i (s4_az_num), .den_i (s4_az_den), .quo_o (az_quo)
  );
  pas_div #(.NW(HT_NW), .DW(HT_DW), .QW(DIV_QW)) u_ht_div (
    .clk_i (clk_i), .en_i (adv), .num_i (s4_ht_num), .den_i (s4_ht_den), .quo_o (ht_quo)
  );
  pas_div #(.NW(RG_NW), .DW(RG_DW), .QW(DIV_QW)) u_rg_div (
    .clk_i (clk_i), .en_i (adv), .num_i (s4_rg_num), .den_i (s4_rg_den), .quo_o (rg_quo)
  );

  // Radial term, with azimuth and height terms held alongside
  logic [16:0] rad;
  logic [16:0] az_t;
  logic [16:0] ht_t;

  pas_exp u_exp (.clk_i (clk_i), .en_i (adv), .x_i (rg_quo), .rad_o (rad));

  pas_delay #(.W(34), .DEPTH(EXP_LAT)) u_term_dly (
    .clk_i (clk_i), .en_i (adv), .d_i ({az_quo[16:0], ht_quo[16:0]}), .q_o ({az_t, ht_t})
  );

  // Weighted sum times azimuth term
  logic [19:0] wsum;
  logic [36:0] s30_prod;
  logic        s30_azok;

  assign wsum = RAW_BASE + {2'b0, rad, 1'b0} + {3'b0, ht_t};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s30_prod <= {20'b0, az_t} * {17'b0, wsum};
      s30_azok <= az_t <= AZ_SHAPE_MAX;
    end
  end

  // Divide by ten through the reciprocal
  logic [39:0] s31_m;
  logic [16:0] s32_raw;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s31_m   <= {20'b0, s30_prod[35:16]} * {20'b0, RECIP_TEN};
      s32_raw <= s31_m[39:23];
    end
  end

  // Threshold and rescale operands; overflowing quotients saturate
  logic [16:0]       mn17;
  logic [16:0]       sc_diff;
  logic [16:0]       sc_den;
  logic              acc;
  logic              sat;
  logic [15:0]       s33_num;
  logic [SC_DW-1:0]  s33_den;
  logic              s33_acc;
  logic              s33_sat;

  assign mn17    = {1'b0, cfg.min_score};
  assign acc     = s32_raw >= mn17;
  assign sc_diff = s32_raw - mn17;
  assign sc_den  = Q_ONE - mn17;
  assign sat     = sc_diff >= sc_den;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s33_num <= (acc && !sat) ? sc_diff[15:0] : '0;
      s33_den <= sc_den;
      s33_acc <= acc;
      s33_sat <= sat;
    end
  end

  logic [SC_QW-1:0] sc_quo;
  logic             pre_e;
  logic             azok_e;
  logic             acc_e;
  logic             sat_e;

  pas_div #(.NW(SC_NW), .DW(SC_DW), .QW(SC_QW)) u_sc_div (
    .clk_i (clk_i), .en_i (adv), .num_i ({s33_num, 16'b0}), .den_i (s33_den),
    .quo_o (sc_quo)
  );

  pas_delay #(.W(1), .DEPTH(ST_SC_OUT - 2)) u_pre_dly (
    .clk_i (clk_i), .en_i (adv), .d_i (s2_pre), .q_o (pre_e)
  );
  pas_delay #(.W(1), .DEPTH(ST_SC_OUT - ST_MUL)) u_azok_dly (
    .clk_i (clk_i), .en_i (adv), .d_i (s30_azok), .q_o (azok_e)
  );
  pas_delay #(.W(2), .DEPTH(SC_QW)) u_acc_dly (
    .clk_i (clk_i), .en_i (adv), .d_i ({s33_acc, s33_sat}), .q_o ({acc_e, sat_e})
  );

  // Result register
  logic [15:0] score_q;
  logic        flag_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      score_q <= !acc_e ? 16'd0 : (sat_e ? 16'hFFFF : sc_quo);
      flag_q  <= acc_e && azok_e && pre_e;
    end
  end

  assign out_o.valid        = vld_q[NSTG-1];
  assign out_o.score        = score_q;
  assign out_o.shape_change = flag_q;

  // Saturated transaction moving into the result register
  logic sat_load;

  assign sat_load = vld_q[ST_SC_OUT-1] && adv && acc_e && sat_e;

  `ASSERT_AT(a_stall_freezes_pipe, clk_i, rst_ni, !adv |=> $stable(vld_q))
  `ASSERT_AT(a_sat_gives_full_score, clk_i, rst_ni, sat_load |=> (out_o.score == 16'hFFFF))
endmodule

### tb/polar_association_score_test.sv
module polar_association_score_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pas_pkg::*;

  // Score fields of one transaction
  typedef struct {
    logic [15:0] score;
    logic        shape;
  } score_t;

  // Directed stimulus row: inputs plus optional typed-in expectation
  typedef struct {
    logic signed [15:0] ac;
    logic [15:0]        ah;
    logic [17:0]        rg;
    logic signed [15:0] zl;
    logic signed [15:0] zh;
    logic [15:0]        ar;
    logic               tr;
    bit                 known;
    logic [15:0]        exp_score;
    logic               exp_shape;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  pas_in_if  meas_ch ();
  pas_out_if score_ch ();

  polar_association_score dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (meas_ch.sink),
    .out_o   (score_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the tracker registers
  logic signed [15:0] t_ac, t_zl, t_zh;
  logic [15:0] t_ah, t_area, t_min;
  logic [17:0] t_rg;
  logic        t_veh;

  score_t expected_scores[$];
  int errors = 0;
  bit feeding_done = 1'b0;
  int max_gap = 3;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Exponential of -x, x in Q.16, by piecewise-linear 2^-f
  function automatic longint exp_neg_q16(longint x);
    longint y, k, f, i, r, v;
    longint tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                        46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                        32768};
    y = (x * 94548) >> 16;
    k = y >> 16;
    if (k > 16) return 0;
    f = y & 16'hFFFF;
    i = f >> 12;
    r = f & 12'hFFF;
    v = tab[i] - (((tab[i] - tab[i+1]) * r) >> 12);
    return v >> k;
  endfunction

  // Predict score and shape flag for one measurement
  function automatic score_t predict_score(logic signed [15:0] ac, logic [15:0] ah,
                                           logic [17:0] rg, logic signed [15:0] zl,
                                           logic signed [15:0] zh, logic [15:0] ar,
                                           logic tr);
    score_t res;
    logic signed [15:0] dd;
    longint d, ha, hb, lft, rgt, inter, uni, az, gap, rmax, rad, ov, span, h, raw, s;
    longint big, sml;
    dd = ac - t_ac;
    d = (dd < 0) ? -longint'(dd) : longint'(dd);
    ha = ah; hb = t_ah;
    lft = (-ha > d - hb) ? -ha : d - hb;
    rgt = (ha < d + hb) ? ha : d + hb;
    inter = (rgt > lft) ? rgt - lft : 0;
    uni = 2 * ha + 2 * hb - inter;
    az = (uni <= 0) ? 0 : inter * 65536 / uni;
    if (az > 65536) az = 65536;
    gap = (rg > t_rg) ? rg - t_rg : t_rg - rg;
    rmax = (rg > t_rg) ? rg : t_rg;
    rad = exp_neg_q16(gap * 6553600 / (200000 + 3 * rmax));
    ov = ((zh < t_zh) ? longint'(zh) : longint'(t_zh)) -
         ((zl > t_zl) ? longint'(zl) : longint'(t_zl));
    if (ov < 0) ov = 0;
    span = ((zh > t_zh) ? longint'(zh) : longint'(t_zh)) -
           ((zl < t_zl) ? longint'(zl) : longint'(t_zl));
    h = (span <= 0) ? 0 : ov * 65536 / span;
    if (h > 65536) h = 65536;
    raw = az * (458752 + 2 * rad + h) / 655360;
    res.score = '0;
    res.shape = 1'b0;
    if (raw >= t_min) begin
      s = (raw - t_min) * 65536 / (65536 - t_min);
      res.score = (s > 65535) ? 16'hFFFF : s[15:0];
      big = (ar > t_area) ? ar : t_area;
      sml = (ar > t_area) ? t_area : ar;
      if (az * 10 < 458752 && t_veh && tr && sml > 0 && big > 2 * sml) res.shape = 1'b1;
    end
    return res;
  endfunction

  // Write one register over the configuration port
  task automatic write_reg(pas_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_AZ_CENTER:    t_ac = val[15:0];
      REG_AZ_HALF_SPAN: t_ah = val[15:0];
      REG_RANGE_MIN:    t_rg = val[17:0];
      REG_Z_MIN:        t_zl = val[15:0];
      REG_Z_MAX:        t_zh = val[15:0];
      REG_AREA:         t_area = val[15:0];
      REG_IS_VEHICLE:   t_veh = val[0];
      REG_MIN_SCORE:    t_min = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_tracker(logic [15:0] ac, logic [15:0] ah, logic [17:0] rg,
                               logic [15:0] zl, logic [15:0] zh, logic [15:0] ar,
                               logic veh, logic [15:0] mn);
    write_reg(REG_AZ_CENTER, 32'(ac));
    write_reg(REG_AZ_HALF_SPAN, 32'(ah));
    write_reg(REG_RANGE_MIN, 32'(rg));
    write_reg(REG_Z_MIN, 32'(zl));
    write_reg(REG_Z_MAX, 32'(zh));
    write_reg(REG_AREA, 32'(ar));
    write_reg(REG_IS_VEHICLE, 32'(veh));
    write_reg(REG_MIN_SCORE, 32'(mn));
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    return $urandom_range(1, max_gap);
  endfunction

  // Hold off until every expected score has come, plus pipeline drain margin
  task automatic drain();
    while (expected_scores.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Send one measurement transaction; queue expectation on acceptance
  task automatic send_meas(row_t r);
    score_t p;
    int g;
    g = pick_gap();
    if (g > 0) begin
      meas_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    meas_ch.valid <= 1'b1;
    meas_ch.meas_az_center <= r.ac;
    meas_ch.meas_az_half_span <= r.ah;
    meas_ch.meas_range_min <= r.rg;
    meas_ch.meas_z_min <= r.zl;
    meas_ch.meas_z_max <= r.zh;
    meas_ch.meas_area <= r.ar;
    meas_ch.extent_trusted <= r.tr;
    do @(posedge clk_i); while (!meas_ch.ready);
    p = predict_score(r.ac, r.ah, r.rg, r.zl, r.zh, r.ar, r.tr);
    if (r.known && (p.score !== r.exp_score || p.shape !== r.exp_shape))
      $display("note: table row disagrees with predictor, using table");
    if (r.known) begin
      p.score = r.exp_score;
      p.shape = r.exp_shape;
    end
    expected_scores.push_back(p);
  endtask

  function automatic row_t rand_row(bit near);
    row_t r;
    r.known = 1'b0;
    r.exp_score = '0;
    r.exp_shape = 1'b0;
    if (near) begin
      r.ac = t_ac + 16'($signed($urandom_range(0, 4000)) - 2000);
      r.ah = (t_ah > 16'd32768) ? 16'($urandom_range(0, 32768))
             : 16'(int'(t_ah) * $urandom_range(1, 40) / 20);
      r.rg = 18'(($urandom_range(0, 1) ? int'(t_rg) : 0) + $urandom_range(0, 6000));
      r.zl = t_zl + 16'($signed($urandom_range(0, 600)) - 300);
      r.zh = r.zl + 16'($urandom_range(0, 3000));
    end else begin
      r.ac = 16'($urandom);
      r.ah = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
      r.rg = 18'($urandom);
      r.zl = 16'($urandom);
      r.zh = 16'($urandom);
    end
    r.ar = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
    r.tr = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Receiver: random backpressure and in-order checking
  initial begin
    score_t e;
    score_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (score_ch.valid && score_ch.ready) begin
        if (expected_scores.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected score transaction %0d", score_ch.score);
        end else begin
          e = expected_scores.pop_front();
          if (score_ch.score !== e.score || score_ch.shape_change !== e.shape) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: score exp %0d got %0d, shape exp %0b got %0b",
                       e.score, score_ch.score, e.shape, score_ch.shape_change);
          end
        end
      end
      score_ch.ready <= (pick_gap() == 0) || feeding_done;
    end
  end

  row_t dir_tab[] = '{
    // all zero registers and input: empty union
    '{16'sd0, 16'd0, 18'd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0},
    '{16'sh7FFF, 16'd32768, 18'h3FFFF, 16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b0, 16'd0, 1'b0},
    '{16'sh8000, 16'hFFFF, 18'd0, 16'sh7FFF, 16'sh8000, 16'd0, 1'b1, 1'b0, 16'd0, 1'b0},
    '{16'sd100, 16'd500, 18'd1000, 16'sd0, 16'sd1500, 16'd50, 1'b1, 1'b0, 16'd0, 1'b0}
  };

  row_t trk_tab[] = '{
    // identical footprint to the tracker below: full score
    '{16'sd1000, 16'd2000, 18'd20000, -16'sd500, 16'sd1500, 16'd200, 1'b1, 1'b1,
      16'd65535, 1'b0},
    // disjoint azimuth: zero
    '{-16'sd31000, 16'd100, 18'd20000, -16'sd500, 16'sd1500, 16'd200, 1'b1, 1'b1,
      16'd0, 1'b0},
    // partial overlap with big area ratio: shape change
    '{16'sd2500, 16'd2000, 18'd20000, -16'sd500, 16'sd1500, 16'd900, 1'b1, 1'b0,
      16'd0, 1'b0},
    '{16'sd2500, 16'd2000, 18'd20000, -16'sd500, 16'sd1500, 16'd900, 1'b0, 1'b0,
      16'd0, 1'b0},
    '{16'sd2500, 16'd2000, 18'd20000, -16'sd500, 16'sd1500, 16'd0, 1'b1, 1'b0,
      16'd0, 1'b0},
    // min above max height: height term zero
    '{16'sd1000, 16'd2000, 18'd200000, 16'sd1500, -16'sd500, 16'd200, 1'b1, 1'b0,
      16'd0, 1'b0},
    '{16'sd1000, 16'd2000, 18'h3FFFF, 16'sd1500, 16'sd1500, 16'd100, 1'b1, 1'b0,
      16'd0, 1'b0},
    // wrap across pi
    '{-16'sd32000, 16'd32768, 18'd19000, -16'sd600, 16'sd1400, 16'd401, 1'b1, 1'b0,
      16'd0, 1'b0}
  };

  // Stimulus
  initial begin
    row_t r;
    int n;
    meas_ch.valid = 1'b0;
    meas_ch.meas_az_center = '0;
    meas_ch.meas_az_half_span = '0;
    meas_ch.meas_range_min = '0;
    meas_ch.meas_z_min = '0;
    meas_ch.meas_z_max = '0;
    meas_ch.meas_area = '0;
    meas_ch.extent_trusted = 1'b0;
    t_ac = 0; t_ah = 0; t_rg = 0; t_zl = 0; t_zh = 0; t_area = 0; t_veh = 0; t_min = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) send_meas(dir_tab[i]);
    meas_ch.valid <= 1'b0;
    drain();
    write_tracker(16'd1000, 16'd2000, 18'd20000, -16'sd500, 16'sd1500, 16'd200, 1'b1, 16'd0);
    foreach (trk_tab[i]) send_meas(trk_tab[i]);
    meas_ch.valid <= 1'b0;
    drain();
    write_reg(REG_MIN_SCORE, 32'd65534);
    send_meas(trk_tab[0]);
    send_meas(trk_tab[2]);
    meas_ch.valid <= 1'b0;
    drain();

    // random phases with fresh tracker settings
    for (int ph = 0; ph < 13; ph++) begin
      max_gap = (ph % 3 == 0) ? 0 : 4;
      case (ph)
        0: write_tracker(16'h8000, 16'd32768, 18'h3FFFF, 16'h8000, 16'h7FFF, 16'hFFFF,
                         1'b1, 16'd0);
        1: write_tracker(16'h7FFF, 16'd0, 18'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd65534);
        default: write_tracker(16'($urandom),
                               16'(($urandom_range(0, 9) == 0) ? $urandom
                                                               : $urandom_range(200, 8000)),
                               18'($urandom_range(0, 100000)),
                               16'(-$urandom_range(0, 2000)), 16'($urandom_range(0, 3000)),
                               16'($urandom_range(1, 400)), $urandom_range(0, 3) != 0,
                               16'(($urandom_range(0, 1)) ? $urandom_range(0, 40000) : 0));
      endcase
      n = 100;
      for (int k = 0; k < n; k++) begin
        r = rand_row($urandom_range(0, 4) != 0);
        send_meas(r);
        if (k == 50 && ph == 4) begin
          meas_ch.valid <= 1'b0;
          drain();
        end
      end
      meas_ch.valid <= 1'b0;
      drain();
    end

    feeding_done = 1'b1;
    n = 0;
    while (expected_scores.size() != 0 && n < 100000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (60) @(posedge clk_i);
    if (errors == 0 && expected_scores.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/pas_pkg.sv
rtl/pas_if.sv
rtl/pas_cfg.sv
rtl/pas_div.sv
rtl/pas_exp.sv
rtl/pas_delay.sv
rtl/polar_association_score.sv
tb/polar_association_score_test.sv
